[sv/fbc_pkg.sv]
// Shared types and constants for the frustum box cull block.
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int FIELD_W = 32;
  localparam int PIDX_W  = 3;
  localparam int LOC_W   = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [LOC_W-1:0] LOC_INSIDE    = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INTERSECT = 2'd1;
  localparam logic [LOC_W-1:0] LOC_OUTSIDE   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_box;
    logic issue;
    logic last;
    logic flush;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic valid;
    logic last;
    logic pos_below;
    logic neg_below;
  } dp_stat_t;

endpackage

[sv/fbc_datapath.sv]
// Plane table, box registers and the pipelined plane distance sign test.
`timescale 1ns / 1ps

module fbc_datapath import fbc_pkg::*; #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32,
  parameter int IDX_W       = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic [COORD_WIDTH-1:0] wr_a,
  input  logic [COORD_WIDTH-1:0] wr_b,
  input  logic [COORD_WIDTH-1:0] wr_c,
  input  logic [COORD_WIDTH-1:0] wr_d,
  input  logic [COORD_WIDTH-1:0] min_x,
  input  logic [COORD_WIDTH-1:0] min_y,
  input  logic [COORD_WIDTH-1:0] min_z,
  input  logic [COORD_WIDTH-1:0] max_x,
  input  logic [COORD_WIDTH-1:0] max_y,
  input  logic [COORD_WIDTH-1:0] max_z,
  input  dp_cmd_t                cmd,
  input  logic [IDX_W-1:0]       plane_idx,
  output dp_stat_t               stat
);

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = 2 * CW;
  localparam int SUM_W = 2 * CW + 2;

  logic signed [CW-1:0] na_r [NUM_PLANES];
  logic signed [CW-1:0] nb_r [NUM_PLANES];
  logic signed [CW-1:0] nc_r [NUM_PLANES];
  logic signed [CW-1:0] nd_r [NUM_PLANES];

  logic signed [CW-1:0] bmin_x_r, bmin_y_r, bmin_z_r;
  logic signed [CW-1:0] bmax_x_r, bmax_y_r, bmax_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        na_r[i] <= '0;
        nb_r[i] <= '0;
        nc_r[i] <= '0;
        nd_r[i] <= '0;
      end
    end else if (wr_en) begin
      na_r[wr_idx] <= wr_a;
      nb_r[wr_idx] <= wr_b;
      nc_r[wr_idx] <= wr_c;
      nd_r[wr_idx] <= wr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_box) begin
      bmin_x_r <= min_x;
      bmin_y_r <= min_y;
      bmin_z_r <= min_z;
      bmax_x_r <= max_x;
      bmax_y_r <= max_y;
      bmax_z_r <= max_z;
    end
  end

  // Stage 1: pick the positive and negative vertex, six products
  logic signed [CW-1:0] a_sel, b_sel, c_sel;
  logic signed [CW-1:0] px, py, pz, qx, qy, qz;
  logic signed [PW-1:0] pos_pr [3];
  logic signed [PW-1:0] neg_pr [3];

  always_comb begin
    a_sel = na_r[plane_idx];
    b_sel = nb_r[plane_idx];
    c_sel = nc_r[plane_idx];
    px = a_sel[CW-1] ? bmin_x_r : bmax_x_r;
    py = b_sel[CW-1] ? bmin_y_r : bmax_y_r;
    pz = c_sel[CW-1] ? bmin_z_r : bmax_z_r;
    qx = a_sel[CW-1] ? bmax_x_r : bmin_x_r;
    qy = b_sel[CW-1] ? bmax_y_r : bmin_y_r;
    qz = c_sel[CW-1] ? bmax_z_r : bmin_z_r;
    pos_pr[0] = a_sel * px;
    pos_pr[1] = b_sel * py;
    pos_pr[2] = c_sel * pz;
    neg_pr[0] = a_sel * qx;
    neg_pr[1] = b_sel * qy;
    neg_pr[2] = c_sel * qz;
  end

  logic signed [PW-1:0] pos_pr_r [3];
  logic signed [PW-1:0] neg_pr_r [3];
  logic signed [CW-1:0] d1_r;
  logic                 vld1_r, last1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pos_pr_r[i] <= pos_pr[i];
      neg_pr_r[i] <= neg_pr[i];
    end
    d1_r    <= nd_r[plane_idx];
    last1_r <= cmd.last;
  end

  // Stage 2: two partial sums per vertex, offset widened to Q34.32
  logic signed [SUM_W-1:0] d_wide;
  logic signed [SUM_W-1:0] pos_sa_r, pos_sb_r, neg_sa_r, neg_sb_r;
  logic                    vld2_r, last2_r;

  assign d_wide = SUM_W'(d1_r) <<< 16;

  always_ff @(posedge clk) begin
    pos_sa_r <= SUM_W'(pos_pr_r[0]) + SUM_W'(pos_pr_r[1]);
    pos_sb_r <= SUM_W'(pos_pr_r[2]) + d_wide;
    neg_sa_r <= SUM_W'(neg_pr_r[0]) + SUM_W'(neg_pr_r[1]);
    neg_sb_r <= SUM_W'(neg_pr_r[2]) + d_wide;
    last2_r  <= last1_r;
  end

  // Stage 3: only the sign of the exact distance is kept
  logic signed [SUM_W-1:0] pos_sum, neg_sum;
  logic                    pos_below_r, neg_below_r, vld3_r, last3_r;

  assign pos_sum = pos_sa_r + pos_sb_r;
  assign neg_sum = neg_sa_r + neg_sb_r;

  always_ff @(posedge clk) begin
    pos_below_r <= pos_sum[SUM_W-1];
    neg_below_r <= neg_sum[SUM_W-1];
    last3_r     <= last2_r;
  end

  // Flush drops every beat still in flight after an early outside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= cmd.issue & ~cmd.flush;
      vld2_r <= vld1_r & ~cmd.flush;
      vld3_r <= vld2_r & ~cmd.flush;
    end
  end

  assign stat.valid     = vld3_r;
  assign stat.last      = last3_r;
  assign stat.pos_below = pos_below_r;
  assign stat.neg_below = neg_below_r;

endmodule

[sv/fbc_ctrl.sv]
// Sequencer: walks the planes, folds the plane results, owns the output register.
`timescale 1ns / 1ps

module fbc_ctrl import fbc_pkg::*; #(
  parameter int NUM_PLANES = 6,
  parameter int IDX_W      = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  output logic [LOC_W-1:0] out_location,
  input  logic             out_stall,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] plane_idx,
  input  dp_stat_t         stat
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PLANES - 1);

  ctl_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             isect_r, isect_nxt;
  logic [LOC_W-1:0] loc_r, loc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LOC_W-1:0] out_loc_r, out_loc_nxt;
  logic             kill;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_location = out_loc_r;
  assign plane_idx    = cnt_r;
  assign kill         = stat.valid & stat.pos_below;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    isect_nxt      = isect_r;
    loc_nxt        = loc_r;
    out_valid_nxt  = out_valid_r;
    out_loc_nxt    = out_loc_r;
    cmd            = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_cmd == CMD_TEST) begin
          cmd.load_box   = 1'b1;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          isect_nxt      = 1'b0;
          state_nxt      = S_RUN;
        end
      end
      S_RUN: begin
        if (!issue_done_r && !kill) begin
          cmd.issue = 1'b1;
          cmd.last  = (cnt_r == LAST_IDX);
          if (cnt_r == LAST_IDX) issue_done_nxt = 1'b1;
          else cnt_nxt = cnt_r + IDX_W'(1);
        end
        if (kill) begin
          // early out: drop what is left in the pipe
          cmd.flush = 1'b1;
          loc_nxt   = LOC_OUTSIDE;
          state_nxt = S_DONE;
        end else if (stat.valid) begin
          if (stat.neg_below) isect_nxt = 1'b1;
          if (stat.last) begin
            loc_nxt   = (stat.neg_below || isect_r) ? LOC_INTERSECT : LOC_INSIDE;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = loc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      issue_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    isect_r   <= isect_nxt;
    loc_r     <= loc_nxt;
    out_loc_r <= out_loc_nxt;
  end

endmodule

[sv/frustum_box_cull.sv]
// Top level of the frustum box cull block: handshake, controller and datapath.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  cmd, plane_index, plane_a..d, box_min/max_x..z
//   out_     output     out_valid/out_stall location
//
// A load beat writes one plane and returns no result. A test beat runs
// from accept to the result register, ending sooner on an early outside:
// one plane enters the three-stage distance pipe per cycle, and the
// sequencer takes no new beat until the result is placed, so a test beat
// must finish before the next beat of either kind is accepted.
// The result register holds while out_stall is high; a new beat is taken
// while it waits. Synchronous reset clears the plane table to zero.
`timescale 1ns / 1ps

module frustum_box_cull import fbc_pkg::*; #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic [PIDX_W-1:0]   in_plane_index,
  input  logic [FIELD_W-1:0]  in_plane_a,
  input  logic [FIELD_W-1:0]  in_plane_b,
  input  logic [FIELD_W-1:0]  in_plane_c,
  input  logic [FIELD_W-1:0]  in_plane_d,
  input  logic [FIELD_W-1:0]  in_box_min_x,
  input  logic [FIELD_W-1:0]  in_box_min_y,
  input  logic [FIELD_W-1:0]  in_box_min_z,
  input  logic [FIELD_W-1:0]  in_box_max_x,
  input  logic [FIELD_W-1:0]  in_box_max_y,
  input  logic [FIELD_W-1:0]  in_box_max_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LOC_W-1:0]    out_location
);

  localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int CW    = COORD_WIDTH;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [IDX_W-1:0] plane_idx;
  logic             in_acc;
  logic             wr_en;

  assign in_acc = in_valid & ~in_stall;
  // drop loads aimed past the table
  assign wr_en  = in_acc && (in_cmd == CMD_LOAD) && (32'(in_plane_index) < NUM_PLANES);

  fbc_ctrl #(
    .NUM_PLANES (NUM_PLANES),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_cmd       (in_cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_location (out_location),
    .out_stall    (out_stall),
    .cmd          (dp_cmd),
    .plane_idx    (plane_idx),
    .stat         (dp_stat)
  );

  fbc_datapath #(
    .NUM_PLANES  (NUM_PLANES),
    .COORD_WIDTH (COORD_WIDTH),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_idx    (IDX_W'(in_plane_index)),
    .wr_a      (in_plane_a[CW-1:0]),
    .wr_b      (in_plane_b[CW-1:0]),
    .wr_c      (in_plane_c[CW-1:0]),
    .wr_d      (in_plane_d[CW-1:0]),
    .min_x     (in_box_min_x[CW-1:0]),
    .min_y     (in_box_min_y[CW-1:0]),
    .min_z     (in_box_min_z[CW-1:0]),
    .max_x     (in_box_max_x[CW-1:0]),
    .max_y     (in_box_max_y[CW-1:0]),
    .max_z     (in_box_max_z[CW-1:0]),
    .cmd       (dp_cmd),
    .plane_idx (plane_idx),
    .stat      (dp_stat)
  );

  // Plane results only arrive while a test is running
  a_stat_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.valid |-> in_stall)
    else $error("plane result outside a running test");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_TEST) |=> in_stall)
    else $error("test beat accepted but sequencer idle");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_LOAD) |=> !in_stall)
    else $error("load beat started a test");

  a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_location == LOC_INSIDE || out_location == LOC_INTERSECT ||
                   out_location == LOC_OUTSIDE))
    else $error("bad location code");

endmodule
